[rtl/ltkm_pkg.sv]
// Shared types and constants of the loser-tree merge unit.
package ltkm_pkg;

  localparam int unsigned MAX_LISTS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_LISTS);
  localparam int unsigned CFG_W     = $clog2(MAX_LISTS + 1);

  localparam logic [CFG_W-1:0] LISTS_RESET = CFG_W'(MAX_LISTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_RD,
    ST_BUILD_CMP,
    ST_REPLAY,
    ST_FINISH
  } state_e;

endpackage

[rtl/ltkm_node_ram.sv]
// Tree node memory with one write port and two registered read ports.
module ltkm_node_ram #(
  parameter int unsigned DATA_W = 72,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/ltkm_ctrl.sv]
// Sequencer for head loading, tree build and path replay, with the result register.
module ltkm_ctrl #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned NODE_W     = $clog2(2 * ltkm_pkg::MAX_LISTS),
  parameter int unsigned ENTRY_W    = 2 * (VALUE_BITS + NODE_W)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [NODE_W-1:0]            n_i,
  input  logic                         restart_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ltkm_pkg::IDX_W-1:0]   list_index_i,
  input  logic [VALUE_BITS-1:0]        list_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [VALUE_BITS-1:0]        merged_value_o,
  output logic [ltkm_pkg::IDX_W-1:0]   from_list_o,
  output logic                         all_done_o,
  output logic                         ram_we_o,
  output logic [NODE_W-1:0]            ram_waddr_o,
  output logic [ENTRY_W-1:0]           ram_wdata_o,
  output logic [NODE_W-1:0]            ram_raddr_a_o,
  output logic [NODE_W-1:0]            ram_raddr_b_o,
  input  logic [ENTRY_W-1:0]           ram_rdata_a_i,
  input  logic [ENTRY_W-1:0]           ram_rdata_b_i
);
  import ltkm_pkg::*;

  localparam int unsigned CMP_W = (NODE_W > IDX_W) ? NODE_W : IDX_W;

  typedef struct packed {
    logic [VALUE_BITS-1:0] loser_val;
    logic [NODE_W-1:0]     loser_leaf;
    logic [VALUE_BITS-1:0] champ_val;
    logic [NODE_W-1:0]     champ_leaf;
  } node_t;

  state_e                state_q, state_d;
  logic [NODE_W-1:0]     heads_q, heads_d;
  logic [NODE_W-1:0]     i_q, i_d;
  logic [NODE_W-1:0]     p_q, p_d;
  logic [VALUE_BITS-1:0] cur_val_q, cur_val_d;
  logic [NODE_W-1:0]     cur_leaf_q, cur_leaf_d;
  logic [VALUE_BITS-1:0] win_val_q, win_val_d;
  logic [NODE_W-1:0]     win_leaf_q, win_leaf_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] merged_q, merged_d;
  logic [IDX_W-1:0]      from_list_q, from_list_d;
  logic                  all_done_q, all_done_d;

  node_t                 rd_a, rd_b, wr_node;
  logic                  left_is_leaf, right_is_leaf;
  logic [VALUE_BITS-1:0] left_val, right_val, bwin_val, blose_val;
  logic [NODE_W-1:0]     left_leaf, right_leaf, bwin_leaf, blose_leaf;
  logic                  swap;
  logic [VALUE_BITS-1:0] nxt_val;
  logic [NODE_W-1:0]     nxt_leaf;
  logic                  out_free;
  logic                  idx_ok;

  assign rd_a = node_t'(ram_rdata_a_i);
  assign rd_b = node_t'(ram_rdata_b_i);

  always_comb begin
    left_is_leaf  = i_q >= n_i;
    right_is_leaf = (i_q + NODE_W'(1)) >= n_i;
    left_val      = left_is_leaf ? rd_a.loser_val : rd_a.champ_val;
    left_leaf     = left_is_leaf ? i_q : rd_a.champ_leaf;
    right_val     = right_is_leaf ? rd_b.loser_val : rd_b.champ_val;
    right_leaf    = right_is_leaf ? (i_q + NODE_W'(1)) : rd_b.champ_leaf;
    if (left_val > right_val) begin
      bwin_val   = left_val;
      bwin_leaf  = left_leaf;
      blose_val  = right_val;
      blose_leaf = right_leaf;
    end else begin
      bwin_val   = right_val;
      bwin_leaf  = right_leaf;
      blose_val  = left_val;
      blose_leaf = left_leaf;
    end
    swap     = cur_val_q < rd_a.loser_val;
    nxt_val  = swap ? rd_a.loser_val : cur_val_q;
    nxt_leaf = swap ? rd_a.loser_leaf : cur_leaf_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_ok   = CMP_W'(list_index_i) < CMP_W'(n_i);

  always_comb begin
    state_d       = state_q;
    heads_d       = heads_q;
    i_d           = i_q;
    p_d           = p_q;
    cur_val_d     = cur_val_q;
    cur_leaf_d    = cur_leaf_q;
    win_val_d     = win_val_q;
    win_leaf_d    = win_leaf_q;
    out_valid_d   = out_valid_q && out_stall_i;
    merged_d      = merged_q;
    from_list_d   = from_list_q;
    all_done_d    = all_done_q;
    ram_we_o      = 1'b0;
    ram_waddr_o   = '0;
    wr_node       = '0;
    ram_raddr_a_o = '0;
    ram_raddr_b_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (heads_q < n_i) begin
            if (idx_ok) begin
              ram_we_o          = 1'b1;
              ram_waddr_o       = n_i + NODE_W'(list_index_i);
              wr_node.loser_val = list_value_i;
              heads_d           = heads_q + NODE_W'(1);
              if ((heads_q + NODE_W'(1)) == n_i) begin
                if (n_i == NODE_W'(1)) begin
                  win_leaf_d = NODE_W'(1);
                  win_val_d  = list_value_i;
                  state_d    = ST_FINISH;
                end else begin
                  i_d     = (n_i << 1) - NODE_W'(2);
                  state_d = ST_BUILD_RD;
                end
              end
            end
          end else if (win_val_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            cur_val_d     = list_value_i;
            cur_leaf_d    = win_leaf_q;
            p_d           = win_leaf_q >> 1;
            ram_raddr_a_o = win_leaf_q >> 1;
            if ((win_leaf_q >> 1) == '0) begin
              win_val_d = list_value_i;
              state_d   = ST_FINISH;
            end else begin
              state_d = ST_REPLAY;
            end
          end
        end
      end
      ST_BUILD_RD: begin
        ram_raddr_a_o = i_q;
        ram_raddr_b_o = i_q + NODE_W'(1);
        state_d       = ST_BUILD_CMP;
      end
      ST_BUILD_CMP: begin
        ram_we_o           = 1'b1;
        ram_waddr_o        = i_q >> 1;
        wr_node.loser_val  = blose_val;
        wr_node.loser_leaf = blose_leaf;
        wr_node.champ_val  = bwin_val;
        wr_node.champ_leaf = bwin_leaf;
        if (i_q == NODE_W'(2)) begin
          win_val_d  = bwin_val;
          win_leaf_d = bwin_leaf;
          state_d    = ST_FINISH;
        end else begin
          i_d     = i_q - NODE_W'(2);
          state_d = ST_BUILD_RD;
        end
      end
      ST_REPLAY: begin
        if (swap) begin
          ram_we_o           = 1'b1;
          ram_waddr_o        = p_q;
          wr_node            = rd_a;
          wr_node.loser_val  = cur_val_q;
          wr_node.loser_leaf = cur_leaf_q;
        end
        if ((p_q >> 1) == '0) begin
          win_val_d  = nxt_val;
          win_leaf_d = nxt_leaf;
          if (out_free) begin
            out_valid_d = 1'b1;
            merged_d    = nxt_val;
            from_list_d = IDX_W'(nxt_leaf - n_i);
            all_done_d  = nxt_val == '0;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          cur_val_d     = nxt_val;
          cur_leaf_d    = nxt_leaf;
          p_d           = p_q >> 1;
          ram_raddr_a_o = p_q >> 1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          merged_d    = win_val_q;
          from_list_d = IDX_W'(win_leaf_q - n_i);
          all_done_d  = win_val_q == '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (restart_i) begin
      heads_d    = '0;
      win_leaf_d = '0;
    end
  end

  assign ram_wdata_o = ENTRY_W'(wr_node);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      heads_q     <= '0;
      win_leaf_q  <= '0;
      win_val_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heads_q     <= heads_d;
      win_leaf_q  <= win_leaf_d;
      win_val_q   <= win_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    p_q         <= p_d;
    cur_val_q   <= cur_val_d;
    cur_leaf_q  <= cur_leaf_d;
    merged_q    <= merged_d;
    from_list_q <= from_list_d;
    all_done_q  <= all_done_d;
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign merged_value_o = merged_q;
  assign from_list_o    = from_list_q;
  assign all_done_o     = all_done_q;

  a_replay_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPLAY |-> p_q != '0)
    else $error("Replay is running without a node to play.");

  a_build_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BUILD_CMP |-> (i_q >= NODE_W'(2)) && (i_q[0] == 1'b0))
    else $error("Build game addresses an invalid sibling pair.");

  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (all_done_o == (merged_value_o == '0)))
    else $error("Completion flag disagrees with the merged value.");

  a_winner_is_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> win_leaf_q >= n_i)
    else $error("Winner does not point at a leaf.");

  a_heads_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heads_q <= n_i)
    else $error("Head count exceeds the number of lists.");

endmodule

[rtl/loser_tree_k_way_merge_unit.sv]
// Top level of the loser-tree merge unit: list count register, sequencer and node memory.
//
// The input channel carries one list_index/list_value beat per item and the output channel
// one merged_value/from_list/all_done beat per result; both use valid and stall. The list
// count is written through the cfg channel and restarts loading; the user must write it
// only while the unit is idle; the block itself does not enforce it. After reset or a list
// count write, the first beats load one head per list at one beat per cycle; beats whose
// index is not below the list count are dropped. The last head starts the build, which
// plays one game per node pair and then emits the largest head. Each further beat refills
// the list of the last result and replays its path through the node memory, one tree level
// per cycle. Once the winning value is zero each beat repeats the final result. Reset
// empties the pipeline and sets the list count to sixteen; the node memory is not cleared.
// The result sits in an output register, so a stalled receiver holds it while the next
// item is taken; the unit then waits before writing the next result.
module loser_tree_k_way_merge_unit #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ltkm_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ltkm_pkg::IDX_W-1:0]   list_index_i,
  input  logic [VALUE_BITS-1:0]        list_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [VALUE_BITS-1:0]        merged_value_o,
  output logic [ltkm_pkg::IDX_W-1:0]   from_list_o,
  output logic                         all_done_o
);
  import ltkm_pkg::*;

  localparam int unsigned NODE_W  = $clog2(2 * MAX_LISTS);
  localparam int unsigned DEPTH   = 2 * MAX_LISTS;
  localparam int unsigned ENTRY_W = 2 * (VALUE_BITS + NODE_W);

  logic [CFG_W-1:0]   lists_q, lists_d;
  logic [NODE_W-1:0]  n_lists;
  logic               cfg_wr;
  logic               ram_we;
  logic [NODE_W-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign lists_d     = cfg_wr ? cfg_data_i : lists_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lists_q <= LISTS_RESET;
    end else begin
      lists_q <= lists_d;
    end
  end

  always_comb begin
    if (lists_q == '0) begin
      n_lists = NODE_W'(1);
    end else if (32'(lists_q) > MAX_LISTS) begin
      n_lists = NODE_W'(MAX_LISTS);
    end else begin
      n_lists = NODE_W'(lists_q);
    end
  end

  ltkm_node_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH),
    .ADDR_W (NODE_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  ltkm_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .NODE_W     (NODE_W),
    .ENTRY_W    (ENTRY_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .n_i            (n_lists),
    .restart_i      (cfg_wr),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .list_index_i   (list_index_i),
    .list_value_i   (list_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .from_list_o    (from_list_o),
    .all_done_o     (all_done_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_a_o  (ram_raddr_a),
    .ram_raddr_b_o  (ram_raddr_b),
    .ram_rdata_a_i  (ram_rdata_a),
    .ram_rdata_b_i  (ram_rdata_b)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the loser-tree merge unit with a scoreboard that predicts each result.
module tb_top;
  import ltkm_pkg::*;

  localparam int unsigned VW         = 31;
  localparam int unsigned NODES      = 2 * MAX_LISTS;
  localparam int unsigned ITEM_GOAL  = 550;
  localparam int unsigned CALM_AT    = 480;
  localparam int unsigned SETTLE_CYC = 40;

  typedef struct {
    logic [VW-1:0]    value;
    logic [IDX_W-1:0] src;
    logic             done;
  } merge_beat_t;

  class merge_scoreboard;
    logic [VW-1:0]    node_val [NODES];
    int unsigned      node_los [NODES];
    int unsigned      winner;
    int unsigned      loaded;
    logic [CFG_W-1:0] lists;
    merge_beat_t      awaited [$];
    int unsigned      items_used;
    int unsigned      beats_seen;
    int unsigned      errors;
    int unsigned      settings;
    int unsigned      fewest;
    int unsigned      most;

    function new();
      foreach (node_val[i]) begin
        node_val[i] = '0;
        node_los[i] = 0;
      end
      winner = 0;
      loaded = 0;
      lists = LISTS_RESET;
      items_used = 0;
      beats_seen = 0;
      errors = 0;
      settings = 0;
      fewest = MAX_LISTS;
      most = 0;
    endfunction

    function int unsigned active();
      if (lists < 1) return 1;
      if (lists > MAX_LISTS) return MAX_LISTS;
      return lists;
    endfunction

    function logic [VW-1:0] head_of(int unsigned pos);
      return (pos < NODES) ? node_val[pos] : '0;
    endfunction

    function void build(int unsigned n);
      int unsigned champ [NODES];
      int unsigned l, r, w, q, j;
      int i;
      foreach (champ[k]) champ[k] = 0;
      for (j = 0; j < n; j++) champ[n + j] = n + j;
      i = 2 * n - 2;
      while (i >= 2) begin
        l = champ[i];
        r = champ[i + 1];
        if (head_of(l) > head_of(r)) begin
          w = l;
          q = r;
        end else begin
          w = r;
          q = l;
        end
        champ[i / 2] = w;
        node_val[i / 2] = head_of(q);
        node_los[i / 2] = q;
        i -= 2;
      end
      winner = champ[1];
    endfunction

    function void replay();
      int unsigned pos, p, held;
      pos = winner;
      p = pos / 2;
      while (p != 0) begin
        if (head_of(pos) < node_val[p]) begin
          held = node_los[p];
          node_val[p] = head_of(pos);
          node_los[p] = pos;
          pos = (held < NODES) ? held : 0;
        end
        p = p / 2;
      end
      winner = pos;
    endfunction

    function void set_lists(logic [CFG_W-1:0] v);
      lists = v;
      loaded = 0;
      winner = 0;
      settings++;
      if (active() < fewest) fewest = active();
      if (active() > most) most = active();
    endfunction

    function void note_item(logic [IDX_W-1:0] idx, logic [VW-1:0] val);
      merge_beat_t e;
      int unsigned n;
      n = active();
      if (loaded < n) begin
        if (idx >= n) return;
        node_val[n + idx] = val;
        loaded++;
        items_used++;
        if (loaded < n) return;
        build(n);
      end else begin
        items_used++;
        if (head_of(winner) != 0) begin
          if (winner < NODES) node_val[winner] = val;
          replay();
        end
      end
      e.value = head_of(winner);
      e.src = IDX_W'((winner >= n) ? winner - n : 0);
      e.done = (e.value == 0);
      awaited.push_back(e);
    endfunction

    function bit exhausted();
      return loaded >= active() && head_of(winner) == 0;
    endfunction

    function logic [IDX_W-1:0] refill_list();
      return IDX_W'((winner >= active()) ? winner - active() : 0);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void check_beat(logic [VW-1:0] v, logic [IDX_W-1:0] f, logic d);
      merge_beat_t e;
      beats_seen++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0h list %0d all_done %0b", v, f, d);
        return;
      end
      e = awaited.pop_front();
      if (v !== e.value || f !== e.src || d !== e.done) begin
        errors++;
        if (errors <= 10)
          $display("result %0d wrong: expected value %0h list %0d all_done %0b, got %0h %0d %0b",
                   beats_seen, e.value, e.src, e.done, v, f, d);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [IDX_W-1:0] list_index_i;
  logic [VW-1:0]    list_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [VW-1:0]    merged_value_o;
  logic [IDX_W-1:0] from_list_o;
  logic             all_done_o;

  merge_scoreboard  sb;
  bit               calm;
  logic [VW-1:0]    lists_q [MAX_LISTS][$];

  loser_tree_k_way_merge_unit #(
    .VALUE_BITS (VW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .list_index_i   (list_index_i),
    .list_value_i   (list_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .from_list_o    (from_list_o),
    .all_done_o     (all_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (out_valid_o && !out_stall_i) sb.check_beat(merged_value_o, from_list_o, all_done_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_lists(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_item(list_index_i, list_value_i);
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        repeat (60) @(negedge clk_i);
      end
    end
  end

  task automatic send_item(input logic [IDX_W-1:0] idx, input logic [VW-1:0] val);
    calm = sb.items_used >= CALM_AT;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    list_index_i <= idx;
    list_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_lists(input logic [CFG_W-1:0] v);
    settle(SETTLE_CYC);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic make_lists(input int unsigned n);
    int unsigned mode, len, j, k;
    logic [VW-1:0] v;
    mode = $urandom_range(0, 2);
    for (j = 0; j < MAX_LISTS; j++) lists_q[j].delete();
    for (j = 0; j < n; j++) begin
      len = (n <= 4) ? $urandom_range(0, 20) : $urandom_range(0, 8);
      if (mode == 1) v = VW'($urandom_range(1, 12));
      else if ($urandom_range(0, 7) == 0) v = '1;
      else v = VW'($urandom);
      if (v == 0) v = 1;
      for (k = 0; k < len; k++) begin
        lists_q[j].push_back(v);
        v = v - VW'($urandom_range(0, v >> $urandom_range(1, 6)));
      end
      lists_q[j].push_back('0);
    end
  endtask

  task automatic random_phase(input int unsigned phase);
    int unsigned order [MAX_LISTS];
    int unsigned n, cfg, r, tmp, tgt;
    int j;
    logic [VW-1:0] v;
    logic [IDX_W-1:0] idx;
    if (phase == 0) cfg = MAX_LISTS;
    else if (phase == 1) cfg = 1;
    else begin
      r = $urandom_range(0, 9);
      if (r == 0) cfg = 1;
      else if (r == 1) cfg = MAX_LISTS;
      else if (r == 2) cfg = 0;
      else if (r == 3) cfg = $urandom_range(MAX_LISTS + 1, 31);
      else cfg = $urandom_range(2, MAX_LISTS - 1);
    end
    write_lists(CFG_W'(cfg));
    n = sb.active();
    make_lists(n);
    for (j = 0; j < n; j++) order[j] = j;
    for (j = n - 1; j >= 1; j--) begin
      r = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[r];
      order[r] = tmp;
    end
    for (j = 0; j < n; j++) begin
      if (n < MAX_LISTS && $urandom_range(0, 9) == 0)
        send_item(IDX_W'($urandom_range(n, MAX_LISTS - 1)), VW'($urandom));
      send_item(IDX_W'(order[j]), lists_q[order[j]].pop_front());
    end
    while (!sb.exhausted()) begin
      tgt = sb.refill_list();
      v = (lists_q[tgt].size() != 0) ? lists_q[tgt].pop_front() : '0;
      idx = IDX_W'(tgt);
      if ($urandom_range(0, 15) == 0) idx = IDX_W'($urandom);
      if ($urandom_range(0, 39) == 0) v = VW'($urandom);
      if ($urandom_range(0, 29) == 0) settle(0);
      send_item(idx, v);
    end
    repeat ($urandom_range(0, 2)) send_item(IDX_W'($urandom), VW'($urandom));
  endtask

  initial begin
    int unsigned phase;
    sb = new();
    rst_ni = 1'b0;
    calm = 1'b0;
    in_valid_i = 1'b0;
    list_index_i = '0;
    list_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Two lists: tie at build, dropped index while loading, wrong index on refill,
    // tie on replay, and a beat after every list has run dry.
    write_lists(CFG_W'(2));
    send_item(IDX_W'(1), '1);
    send_item(IDX_W'(5), VW'(3));
    send_item(IDX_W'(0), '1);
    send_item(IDX_W'(0), VW'(5));
    settle(0);
    send_item(IDX_W'(0), VW'(5));
    send_item(IDX_W'(0), '0);
    send_item(IDX_W'(1), '0);
    send_item(IDX_W'(15), VW'(1));

    // A count of zero behaves as a single list.
    write_lists(CFG_W'(0));
    send_item(IDX_W'(15), '1);
    send_item(IDX_W'(0), VW'(1));
    send_item(IDX_W'(3), '0);
    send_item(IDX_W'(0), VW'(9));

    // Heads loaded in reverse order, then both lists run dry.
    write_lists(CFG_W'(2));
    send_item(IDX_W'(1), VW'(9));
    send_item(IDX_W'(0), VW'(7));
    send_item(IDX_W'(1), '0);
    send_item(IDX_W'(0), '0);

    phase = 0;
    while (sb.items_used < ITEM_GOAL) begin
      random_phase(phase);
      phase++;
    end

    settle(SETTLE_CYC);
    $display("Run covered %0d input beats over %0d list-count writes (%0d to %0d lists).",
             sb.items_used, sb.settings, sb.fewest, sb.most);
    $display("%0d results checked, %0d faulty.", sb.beats_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
